FILE: rtl/jbt_pkg.sv
// Package: shared types, codes and helper functions of the JSON byte tokeniser
`timescale 1ns / 1ps
package jbt_pkg;

    localparam int LINE_BITS_DEF = 24;
    localparam int QDEPTH_DEF    = 4;
    localparam int LINE_OUT_W    = 24;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_KEYWORD = 4'd1,
        M_STRING  = 4'd2,
        M_ESCAPE  = 4'd3,
        M_HEX     = 4'd4,
        M_NSIGN   = 4'd5,
        M_NZERO   = 4'd6,
        M_NINT    = 4'd7,
        M_NFRAC   = 4'd8,
        M_NEXP    = 4'd9,
        M_NEXPDIG = 4'd10
    } t_mode;

    typedef enum logic [3:0] {
        K_NULL   = 4'd0,
        K_TRUE   = 4'd1,
        K_FALSE  = 4'd2,
        K_STRING = 4'd3,
        K_NUMBER = 4'd4,
        K_LBRACE = 4'd5,
        K_RBRACE = 4'd6,
        K_LBRACK = 4'd7,
        K_RBRACK = 4'd8,
        K_COMMA  = 4'd9,
        K_COLON  = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE    = 3'd0,
        E_KEYWORD = 3'd1,
        E_ESCAPE  = 3'd2,
        E_UNTERM  = 3'd3,
        E_CHAR    = 3'd4
    } t_err;

    // One result without its line number
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       dv;
        logic       te;
        logic [2:0] err;
    } t_tok;

    // All results caused by one input item
    typedef struct packed {
        logic [1:0]            cnt;
        logic [LINE_OUT_W-1:0] line;
        t_tok [2:0]            res;
    } t_bundle;

    function automatic t_tok mk(input t_kind kind, input logic [7:0] data,
                                input logic dv, input logic te, input t_err err);
        t_tok t;
        t.kind = kind;
        t.data = data;
        t.dv   = dv;
        t.te   = te;
        t.err  = err;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Returns {valid, nibble}
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_digit(c)) begin
            d = c - "0";
            return {1'b1, d[3:0]};
        end
        if ((c >= "A") && (c <= "F")) begin
            d = c - "A" + 8'd10;
            return {1'b1, d[3:0]};
        end
        if ((c >= "a") && (c <= "f")) begin
            d = c - "a" + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        case (k)
            2'd2:    return 3'd5;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        case ({k, pos})
            5'b00_000: return "n";
            5'b00_001: return "u";
            5'b00_010: return "l";
            5'b00_011: return "l";
            5'b01_000: return "t";
            5'b01_001: return "r";
            5'b01_010: return "u";
            5'b01_011: return "e";
            5'b10_000: return "f";
            5'b10_001: return "a";
            5'b10_010: return "l";
            5'b10_011: return "s";
            5'b10_100: return "e";
            default:   return 8'd0;
        endcase
    endfunction

    // Keep those keywords whose next letter matches
    function automatic logic [2:0] kw_keep(input logic [2:0] cand, input logic [2:0] pos,
                                           input logic [7:0] c);
        logic [2:0] keep;
        keep = 3'd0;
        for (int k = 0; k < 3; k++) begin
            if (cand[k] && (pos < kw_len(2'(k))) && (kw_char(2'(k), pos) == c)) begin
                keep[k] = 1'b1;
            end
        end
        return keep;
    endfunction

    // Next number mode, or M_IDLE when the byte ends the number
    function automatic t_mode number_next(input t_mode m, input logic [7:0] c);
        logic d, e, dot;
        d   = is_digit(c);
        e   = (c == "e") || (c == "E");
        dot = (c == ".");
        case (m)
            M_NSIGN: begin
                if (d) return (c == "0") ? M_NZERO : M_NINT;
                return dot ? M_NFRAC : (e ? M_NEXP : M_IDLE);
            end
            M_NZERO: return dot ? M_NFRAC : (e ? M_NEXP : M_IDLE);
            M_NINT:  return d ? M_NINT : (dot ? M_NFRAC : (e ? M_NEXP : M_IDLE));
            M_NFRAC: return d ? M_NFRAC : (e ? M_NEXP : M_IDLE);
            M_NEXP:  return (d || (c == "+") || (c == "-")) ? M_NEXPDIG : M_IDLE;
            default: return d ? M_NEXPDIG : M_IDLE;
        endcase
    endfunction

endpackage

FILE: rtl/jbt_ifs.sv
// Interfaces: input byte channel and token result channel
`timescale 1ns / 1ps
interface jbt_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] char_byte;
    modport source(output valid, func, char_byte, input ready);
    modport sink(input valid, func, char_byte, output ready);
endinterface

interface jbt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        token_end;
    logic [2:0]  error_code;
    logic [23:0] line_number;
    logic        last_of_step;
    modport source(output valid, token_kind, data_byte, data_valid, token_end, error_code,
                   line_number, last_of_step, input ready);
    modport sink(input valid, token_kind, data_byte, data_valid, token_end, error_code,
                 line_number, last_of_step, output ready);
endinterface

FILE: rtl/jbt_front.sv
// Front end: takes bytes, runs the scanner, pushes a bundle per item with results
`timescale 1ns / 1ps
module jbt_front #(
    parameter int LINE_BITS = jbt_pkg::LINE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jbt_in_if.sink           i_byte,
    input  logic             i_full,
    output logic             o_push,
    output jbt_pkg::t_bundle o_bun
);
    import jbt_pkg::*;

    localparam int LW = (LINE_BITS > LINE_OUT_W) ? LINE_BITS : LINE_OUT_W;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    t_mode                r_mode, n_mode;
    logic [2:0]           r_cand, n_cand;
    logic [2:0]           r_pos, n_pos;
    logic [15:0]          r_hex, n_hex;
    logic [1:0]           r_hexn, n_hexn;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic                 r_halt, n_halt;

    logic       accept;
    logic [7:0] c;
    logic [LW-1:0] line_ext;

    assign i_byte.ready = !i_full;
    assign accept       = i_byte.valid && !i_full;
    assign c            = i_byte.char_byte;
    assign line_ext     = LW'(r_line);

    // Scan one item and collect its results
    always_comb begin
        logic [1:0]  cnt;
        t_tok [2:0]  res;
        logic        fin, cls, inc, found;
        logic [2:0]  keep;
        logic [4:0]  h;
        logic [15:0] v;
        t_mode       nx;
        cnt = 2'd0;
        res = '0;
        fin = 1'b0;
        cls = 1'b0;
        inc = 1'b0;
        found = 1'b0;
        keep = 3'd0;
        h = 5'd0;
        v = 16'd0;
        nx = M_IDLE;
        n_mode = r_mode;
        n_cand = r_cand;
        n_pos  = r_pos;
        n_hex  = r_hex;
        n_hexn = r_hexn;
        n_line = r_line;
        n_halt = r_halt;

        if (accept && !r_halt) begin
            if (i_byte.func) begin
                inc = 1'b1;
                if (r_mode == M_STRING || r_mode == M_ESCAPE || r_mode == M_HEX) begin
                    res[cnt] = mk(K_STRING, 8'd0, 1'b0, 1'b1, E_UNTERM);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                    n_hexn = 2'd0;
                end else begin
                    fin = 1'b1;
                end
            end else if (r_mode == M_STRING) begin
                if (c == "\\") begin
                    n_mode = M_ESCAPE;
                end else if (c == "\"") begin
                    res[cnt] = mk(K_STRING, 8'd0, 1'b0, 1'b1, E_NONE);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    res[cnt] = mk(K_STRING, c, 1'b1, 1'b0, E_NONE);
                    cnt = cnt + 2'd1;
                end
            end else if (r_mode == M_ESCAPE) begin
                n_mode = M_STRING;
                case (c)
                    "\"", "\\", "/": res[cnt] = mk(K_STRING, c, 1'b1, 1'b0, E_NONE);
                    "r": res[cnt] = mk(K_STRING, 8'h0D, 1'b1, 1'b0, E_NONE);
                    "t": res[cnt] = mk(K_STRING, 8'h09, 1'b1, 1'b0, E_NONE);
                    "n": res[cnt] = mk(K_STRING, 8'h0A, 1'b1, 1'b0, E_NONE);
                    "f": res[cnt] = mk(K_STRING, 8'h0C, 1'b1, 1'b0, E_NONE);
                    "b": res[cnt] = mk(K_STRING, 8'h08, 1'b1, 1'b0, E_NONE);
                    "u": begin
                        n_hex  = 16'd0;
                        n_hexn = 2'd0;
                        n_mode = M_HEX;
                    end
                    default: begin
                        res[cnt] = mk(K_NULL, 8'd0, 1'b0, 1'b0, E_ESCAPE);
                        n_halt = 1'b1;
                        n_mode = M_IDLE;
                    end
                endcase
                if (c != "u") cnt = cnt + 2'd1;
            end else if (r_mode == M_HEX) begin
                h = hex_of(c);
                if (!h[4]) begin
                    res[cnt] = mk(K_NULL, 8'd0, 1'b0, 1'b0, E_ESCAPE);
                    cnt = cnt + 2'd1;
                    n_halt = 1'b1;
                    n_mode = M_IDLE;
                end else begin
                    v = {r_hex[11:0], h[3:0]};
                    n_hex = v;
                    if (r_hexn != 2'd3) begin
                        n_hexn = r_hexn + 2'd1;
                    end else begin
                        // Encode the code point as UTF-8
                        n_hexn = 2'd0;
                        n_mode = M_STRING;
                        if (v < 16'h0080) begin
                            res[0] = mk(K_STRING, v[7:0], 1'b1, 1'b0, E_NONE);
                            cnt = 2'd1;
                        end else if (v < 16'h0800) begin
                            res[0] = mk(K_STRING, {3'b110, v[10:6]}, 1'b1, 1'b0, E_NONE);
                            res[1] = mk(K_STRING, {2'b10, v[5:0]}, 1'b1, 1'b0, E_NONE);
                            cnt = 2'd2;
                        end else begin
                            res[0] = mk(K_STRING, {4'b1110, v[15:12]}, 1'b1, 1'b0, E_NONE);
                            res[1] = mk(K_STRING, {2'b10, v[11:6]}, 1'b1, 1'b0, E_NONE);
                            res[2] = mk(K_STRING, {2'b10, v[5:0]}, 1'b1, 1'b0, E_NONE);
                            cnt = 2'd3;
                        end
                    end
                end
            end else if (r_mode >= M_NSIGN) begin
                nx = number_next(r_mode, c);
                if (nx != M_IDLE) begin
                    res[cnt] = mk(K_NUMBER, (c == "E") ? 8'("e") : c, 1'b1, 1'b0, E_NONE);
                    cnt = cnt + 2'd1;
                    n_mode = nx;
                end else begin
                    fin = 1'b1;
                    cls = 1'b1;
                end
            end else if (r_mode == M_KEYWORD) begin
                if (is_alpha(c)) begin
                    keep = kw_keep(r_cand, r_pos, c);
                    n_cand = keep;
                    if (r_pos != 3'd7) n_pos = r_pos + 3'd1;
                    if (keep == 3'd0) begin
                        res[cnt] = mk(K_NULL, 8'd0, 1'b0, 1'b0, E_KEYWORD);
                        cnt = cnt + 2'd1;
                        n_halt = 1'b1;
                        n_mode = M_IDLE;
                    end
                end else begin
                    fin = 1'b1;
                    cls = 1'b1;
                end
            end else begin
                cls = 1'b1;
            end
        end

        // End a pending number or keyword
        if (fin) begin
            n_mode = M_IDLE;
            if (r_mode >= M_NSIGN) begin
                res[cnt] = mk(K_NUMBER, 8'd0, 1'b0, 1'b1, E_NONE);
                cnt = cnt + 2'd1;
            end else if (r_mode == M_KEYWORD) begin
                for (int k = 0; k < 3; k++) begin
                    if (!found && r_cand[k] && (r_pos == kw_len(2'(k)))) begin
                        res[cnt] = mk(t_kind'(4'(k)), 8'd0, 1'b0, 1'b1, E_NONE);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    res[cnt] = mk(K_NULL, 8'd0, 1'b0, 1'b0, E_KEYWORD);
                    n_halt = 1'b1;
                end
                cnt = cnt + 2'd1;
            end
        end

        // Classify a byte seen between tokens
        if (cls && !n_halt && !is_space(c)) begin
            if (c == "-" || is_digit(c)) begin
                n_mode = (c == "-") ? M_NSIGN : ((c == "0") ? M_NZERO : M_NINT);
                res[cnt] = mk(K_NUMBER, c, 1'b1, 1'b0, E_NONE);
                cnt = cnt + 2'd1;
            end else if (is_alpha(c)) begin
                keep = kw_keep(3'b111, 3'd0, c);
                n_cand = keep;
                n_pos  = 3'd1;
                n_mode = M_KEYWORD;
                if (keep == 3'd0) begin
                    res[cnt] = mk(K_NULL, 8'd0, 1'b0, 1'b0, E_KEYWORD);
                    cnt = cnt + 2'd1;
                    n_halt = 1'b1;
                    n_mode = M_IDLE;
                end
            end else begin
                case (c)
                    "\"": n_mode = M_STRING;
                    "{": res[cnt] = mk(K_LBRACE, 8'd0, 1'b0, 1'b1, E_NONE);
                    "}": res[cnt] = mk(K_RBRACE, 8'd0, 1'b0, 1'b1, E_NONE);
                    "[": res[cnt] = mk(K_LBRACK, 8'd0, 1'b0, 1'b1, E_NONE);
                    "]": res[cnt] = mk(K_RBRACK, 8'd0, 1'b0, 1'b1, E_NONE);
                    ",": res[cnt] = mk(K_COMMA, 8'd0, 1'b0, 1'b1, E_NONE);
                    ":": res[cnt] = mk(K_COLON, 8'd0, 1'b0, 1'b1, E_NONE);
                    default: begin
                        res[cnt] = mk(K_NULL, 8'd0, 1'b0, 1'b0, E_CHAR);
                        n_halt = 1'b1;
                        n_mode = M_IDLE;
                    end
                endcase
                if (c != "\"") cnt = cnt + 2'd1;
            end
        end

        // Count lines, saturating
        if (inc && !n_halt && (r_line != LINE_MAX)) n_line = r_line + 1'b1;

        o_push     = (cnt != 2'd0);
        o_bun.cnt  = cnt;
        o_bun.line = line_ext[LINE_OUT_W-1:0];
        o_bun.res  = res;
    end

    // Hold scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cand <= 3'd0;
            r_pos  <= 3'd0;
            r_hex  <= 16'd0;
            r_hexn <= 2'd0;
            r_line <= LINE_BITS'(1);
            r_halt <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_cand <= n_cand;
            r_pos  <= n_pos;
            r_hex  <= n_hex;
            r_hexn <= n_hexn;
            r_line <= n_line;
            r_halt <= n_halt;
        end
    end

    // Once halted, nothing more is queued
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> !o_push) else $error("result produced while halted");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared without reset");
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0) else $error("line counter at zero");

endmodule

FILE: rtl/jbt_queue.sv
// Bundle queue between the scanner and the result serialiser
`timescale 1ns / 1ps
module jbt_queue #(
    parameter int QDEPTH = jbt_pkg::QDEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jbt_pkg::t_bundle i_bun,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output jbt_pkg::t_bundle o_bun
);
    import jbt_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_bundle       r_mem [QDEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_bun   = r_mem[r_rp];

    // Advance pointers and occupancy
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) n_wp = (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        if (i_pop)  n_rp = (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the incoming bundle
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bun;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QDEPTH)) else $error("queue occupancy out of range");

endmodule

FILE: rtl/jbt_back.sv
// Back end: holds one bundle and hands its results out one transfer at a time
`timescale 1ns / 1ps
module jbt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  jbt_pkg::t_bundle i_bun,
    output logic             o_pop,
    jbt_out_if.source        o_tok
);
    import jbt_pkg::*;

    t_bundle    r_bun;
    logic       r_have, n_have;
    logic [1:0] r_idx, n_idx;
    logic       last;
    t_tok       cur;

    assign cur  = r_bun.res[r_idx];
    assign last = (r_idx == (r_bun.cnt - 2'd1));

    // Drive the result channel from the held bundle
    assign o_tok.valid        = r_have;
    assign o_tok.token_kind   = cur.kind;
    assign o_tok.data_byte    = cur.data;
    assign o_tok.data_valid   = cur.dv;
    assign o_tok.token_end    = cur.te;
    assign o_tok.error_code   = cur.err;
    assign o_tok.line_number  = r_bun.line;
    assign o_tok.last_of_step = last;

    // Load the next bundle once the current one is drained
    always_comb begin
        o_pop  = 1'b0;
        n_have = r_have;
        n_idx  = r_idx;
        if (r_have && o_tok.ready) begin
            if (last) begin
                n_have = 1'b0;
                n_idx  = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (!n_have && !i_empty) begin
            o_pop  = 1'b1;
            n_have = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_have <= n_have;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_bun <= i_bun;
    end

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_bun.cnt != 2'd0)) else $error("empty bundle held");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_idx < r_bun.cnt)) else $error("result index past bundle");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have && !o_tok.ready) |=> (r_have && $stable(r_idx)))
        else $error("result moved during stall");

endmodule

FILE: rtl/json_byte_tokenizer.sv
// Top level: JSON byte tokeniser, scanner front end, bundle queue and serialiser
//
//  Channel   Dir  Payload
//  i_byte    in   func, char_byte
//  o_tok     out  token_kind, data_byte, data_valid, token_end, error_code,
//                 line_number, last_of_step
//
// One byte is taken per cycle while the queue has room; results pass through the queue.
// An item with n results holds the serialiser for n transfers (n up to 3, via \u escapes).
// The QDEPTH-entry queue absorbs those bursts; a full queue drops i_byte.ready.
// Synchronous active-low reset; no clearing pass. A halt after an error lasts until reset.
`timescale 1ns / 1ps
module json_byte_tokenizer #(
    parameter int LINE_BITS = jbt_pkg::LINE_BITS_DEF,
    parameter int QDEPTH    = jbt_pkg::QDEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jbt_in_if.sink    i_byte,
    jbt_out_if.source o_tok
);
    import jbt_pkg::*;

    logic    push, pop, full, empty;
    t_bundle wr_bun, rd_bun;

    jbt_front #(.LINE_BITS(LINE_BITS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (i_byte),
        .i_full (full),
        .o_push (push),
        .o_bun  (wr_bun)
    );

    jbt_queue #(.QDEPTH(QDEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_bun  (wr_bun),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_bun  (rd_bun)
    );

    jbt_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_bun  (rd_bun),
        .o_pop  (pop),
        .o_tok  (o_tok)
    );

endmodule
